/* design/hash_index_lookup_top_assert.svh */
// Assertion macros for the index lookup block.
`ifndef HASH_INDEX_LOOKUP_TOP_ASSERT_SVH
`define HASH_INDEX_LOOKUP_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HIL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hil_pkg.sv */
`timescale 1ns / 1ps

package hil_pkg;

    // Table geometry.
    localparam int ENTRIES   = 1024;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int KEY_W     = 160;
    localparam int KEY_BYTES = 20;
    localparam int FAN_DEPTH = 256;

    // Divider: numerator is (range - 1) times a 17-bit difference.
    localparam int VAL_W = 17;
    localparam int NUM_W = CNT_W + VAL_W;
    localparam int DCNT_W = 5;

    // Stream widths.
    localparam int S_TDATA_W = 240;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 80;

    // Item kinds carried in tuser.
    localparam logic [2:0] MODE_LOOKUP = 3'd0;
    localparam logic [2:0] MODE_FANOUT = 3'd1;
    localparam logic [2:0] MODE_KEY    = 3'd2;
    localparam logic [2:0] MODE_OFS    = 3'd3;
    localparam logic [2:0] MODE_LARGE  = 3'd4;

    typedef logic [KEY_W-1:0] key_t;

    // Byte idx of a key, byte 0 being the most significant.
    function automatic logic [7:0] key_byte(input key_t key, input logic [4:0] idx);
        logic [7:0] r;
        r = 8'd0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (idx == 5'(i)) begin
                r = key[KEY_W-1-8*i -: 8];
            end
        end
        return r;
    endfunction

    // Two bytes starting at ofs, or one byte when ofs is the last byte.
    function automatic logic [15:0] key_pair(input key_t key, input logic [4:0] ofs);
        logic [15:0] r;
        if (ofs < 5'(KEY_BYTES - 1)) begin
            r = {key_byte(key, ofs), key_byte(key, ofs + 5'd1)};
        end else begin
            r = {8'd0, key_byte(key, ofs)};
        end
        return r;
    endfunction

    // Mask that keeps the bytes at and after ofs.
    function automatic key_t tail_mask(input logic [4:0] ofs);
        key_t m;
        m = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (5'(i) >= ofs) begin
                m[KEY_W-1-8*i -: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

/* design/hash_index_lookup_top.sv */
`timescale 1ns / 1ps
// Load beats raise an all-zero result beat: acceptance moves the sequencer to S_DONE,
// which posts the beat once the output is free. Each lookup probe runs the restoring
// divider. At most one item is in work at a time.
// Reset (aresetn low, synchronous) clears the control state, the output valid
// and entry_count; the table memories keep their contents and are not cleared.

module hash_index_lookup_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [hil_pkg::CNT_W-1:0]      cfg_wr_data,  // entry_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // slot[9:0], key_top[41:10], key_middle[105:42], key_bottom[169:106],
    // load_word[233:170], zero fill above
    input  logic [hil_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [hil_pkg::S_TUSER_W-1:0]  s_tuser,      // mode[2:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found[0], position[10:1], object_offset[74:11], table_error[75], zero fill
    output logic [hil_pkg::M_TDATA_W-1:0]  m_tdata
);

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_FAN_HI  = 16'h0002,
        S_FAN_LO  = 16'h0004,
        S_BOUND   = 16'h0008,
        S_RD_LO   = 16'h0010,
        S_RD_HI   = 16'h0020,
        S_EST     = 16'h0040,
        S_VAL     = 16'h0080,
        S_DIV     = 16'h0100,
        S_MID     = 16'h0200,
        S_PRB_RD  = 16'h0400,
        S_PRB_CMP = 16'h0800,
        S_OFS_RD  = 16'h1000,
        S_OFS_USE = 16'h2000,
        S_LRG_USE = 16'h4000,
        S_DONE    = 16'h8000
    } state_t;

    // Table memories.
    hil_pkg::key_t             key_mem   [hil_pkg::ENTRIES];
    logic [hil_pkg::CNT_W-1:0] fan_mem   [hil_pkg::FAN_DEPTH];
    logic [31:0]               ofs_mem   [hil_pkg::ENTRIES];
    logic [63:0]               large_mem [hil_pkg::ENTRIES];

    hil_pkg::key_t             key_rd_reg;
    logic [hil_pkg::CNT_W-1:0] fan_rd_reg;
    logic [31:0]               ofs_rd_reg;
    logic [63:0]               large_rd_reg;

    state_t                    state_reg;
    logic [hil_pkg::CNT_W-1:0] cnt_reg;
    hil_pkg::key_t             key_reg;
    hil_pkg::key_t             lo_key_reg;
    hil_pkg::key_t             hi_key_reg;
    logic [hil_pkg::CNT_W-1:0] lo_reg;
    logic [hil_pkg::CNT_W-1:0] hi_reg;
    logic                      hi_valid_reg;
    logic [4:0]                ofs_reg;
    logic [hil_pkg::IDX_W-1:0] mi_reg;
    logic [hil_pkg::NUM_W-1:0] num_reg;
    logic [hil_pkg::VAL_W:0]   rem_reg;
    logic [hil_pkg::VAL_W-1:0] den_reg;
    logic [hil_pkg::DCNT_W-1:0] dcnt_reg;

    logic                      found_reg;
    logic [hil_pkg::IDX_W-1:0] pos_reg;
    logic [63:0]               offset_reg;
    logic                      err_reg;

    logic                          m_tvalid_reg;
    logic [hil_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Input beat fields.
    logic [2:0]                in_mode;
    logic [hil_pkg::IDX_W-1:0] in_slot;
    hil_pkg::key_t             in_key;
    logic [63:0]               in_word;
    logic                      in_accept;

    assign in_mode   = s_tuser[2:0];
    assign in_slot   = s_tdata[9:0];
    assign in_key    = {s_tdata[41:10], s_tdata[105:42], s_tdata[169:106]};
    assign in_word   = s_tdata[233:170];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Read addresses.
    logic [7:0]                fb;
    logic [7:0]                fan_addr;
    logic [hil_pkg::IDX_W-1:0] key_addr;

    assign fb = key_reg[hil_pkg::KEY_W-1 -: 8];

    always_comb begin
        fan_addr = fb;
        if (state_reg == S_FAN_LO) begin
            fan_addr = fb - 8'd1;
        end
        case (state_reg)
            S_RD_HI:  key_addr = hi_reg[hil_pkg::IDX_W-1:0];
            S_PRB_RD: key_addr = mi_reg;
            default:  key_addr = lo_reg[hil_pkg::IDX_W-1:0];
        endcase
    end

    // Memory writes on load beats, registered reads every cycle.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            case (in_mode)
                hil_pkg::MODE_FANOUT: begin
                    if (in_slot[9:8] == 2'd0) begin
                        fan_mem[in_slot[7:0]] <= in_word[hil_pkg::CNT_W-1:0];
                    end
                end
                hil_pkg::MODE_KEY:   key_mem[in_slot]   <= in_key;
                hil_pkg::MODE_OFS:   ofs_mem[in_slot]   <= in_word[31:0];
                hil_pkg::MODE_LARGE: large_mem[in_slot] <= in_word;
                default: begin
                end
            endcase
        end
        key_rd_reg   <= key_mem[key_addr];
        fan_rd_reg   <= fan_mem[fan_addr];
        ofs_rd_reg   <= ofs_mem[mi_reg];
        large_rd_reg <= large_mem[ofs_rd_reg[hil_pkg::IDX_W-1:0]];
    end

    // First byte at or after the current offset where the range ends differ.
    hil_pkg::key_t lo_cur;
    logic [4:0]    first_diff;

    always_comb begin
        lo_cur = hi_valid_reg ? lo_key_reg : key_rd_reg;
        first_diff = 5'(hil_pkg::KEY_BYTES);
        for (int i = hil_pkg::KEY_BYTES - 1; i >= 0; i--) begin
            if (5'(i) >= ofs_reg &&
                hil_pkg::key_byte(lo_cur, 5'(i)) != hil_pkg::key_byte(key_rd_reg, 5'(i))) begin
                first_diff = 5'(i);
            end
        end
    end

    // Midpoint estimate from the two-byte values at the current offset.
    logic [hil_pkg::VAL_W-1:0] lov;
    logic [hil_pkg::VAL_W-1:0] hiv;
    logic [hil_pkg::VAL_W-1:0] kyv;
    logic [19:0]               blend;
    logic [hil_pkg::VAL_W-1:0] kyv_adj;
    logic [hil_pkg::CNT_W-1:0] span;
    logic [hil_pkg::NUM_W-1:0] product;

    always_comb begin
        lov = {1'b0, hil_pkg::key_pair(lo_key_reg, ofs_reg)};
        kyv = {1'b0, hil_pkg::key_pair(key_reg, ofs_reg)};
        if (hi_valid_reg) begin
            hiv = {1'b0, hil_pkg::key_pair(hi_key_reg, ofs_reg)};
        end else if (ofs_reg < 5'(hil_pkg::KEY_BYTES - 1)) begin
            hiv = 17'h10000;
        end else begin
            hiv = 17'h00100;
        end
        blend   = 20'(kyv) * 20'd6 + 20'(lov) + 20'(hiv);
        kyv_adj = blend[19:3];
        if (lov < hiv - 17'd1) begin
            if (kyv_adj == lov) begin
                kyv_adj = kyv_adj + 17'd1;
            end else if (kyv_adj == hiv) begin
                kyv_adj = kyv_adj - 17'd1;
            end
        end
        span    = hi_reg - lo_reg - 11'd1;
        product = hil_pkg::NUM_W'(span) * hil_pkg::NUM_W'(kyv_adj - lov);
    end

    // Divider step.
    logic [hil_pkg::VAL_W:0] rem_sh;
    logic                    rem_ge;

    assign rem_sh = {rem_reg[hil_pkg::VAL_W-1:0], num_reg[hil_pkg::NUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, den_reg};

    // Midpoint and probe compare.
    logic [hil_pkg::NUM_W:0]   mi_sum;
    hil_pkg::key_t             cmp_mask;
    hil_pkg::key_t             probe_m;
    hil_pkg::key_t             key_m;
    logic [hil_pkg::CNT_W-1:0] lo_up;
    logic [hil_pkg::CNT_W-1:0] mi_ext;

    assign mi_sum   = (hil_pkg::NUM_W+1)'(num_reg) + (hil_pkg::NUM_W+1)'(lo_reg);
    assign cmp_mask = hil_pkg::tail_mask(ofs_reg);
    assign probe_m  = key_rd_reg & cmp_mask;
    assign key_m    = key_reg & cmp_mask;
    assign mi_ext   = {1'b0, mi_reg};
    assign lo_up    = mi_ext + 11'd1;

    // Control sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cnt_reg <= cfg_wr_data;
            end
            // Output valid: raised when a result is posted, dropped when taken.
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        key_reg    <= in_key;
                        found_reg  <= 1'b0;
                        pos_reg    <= '0;
                        offset_reg <= '0;
                        err_reg    <= 1'b0;
                        state_reg  <= (in_mode == hil_pkg::MODE_LOOKUP) ? S_FAN_HI : S_DONE;
                    end
                end
                S_FAN_HI: state_reg <= S_FAN_LO;
                S_FAN_LO: begin
                    hi_reg    <= fan_rd_reg;
                    state_reg <= S_BOUND;
                end
                S_BOUND: begin
                    lo_reg       <= (fb == 8'd0) ? '0 : fan_rd_reg;
                    hi_valid_reg <= (hi_reg != cnt_reg);
                    ofs_reg      <= '0;
                    if (cnt_reg > hil_pkg::CNT_W'(hil_pkg::ENTRIES) || hi_reg > cnt_reg) begin
                        err_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end else if (cnt_reg == '0 ||
                                 ((fb == 8'd0) ? '0 : fan_rd_reg) >= hi_reg) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_RD_LO;
                    end
                end
                S_RD_LO: state_reg <= hi_valid_reg ? S_RD_HI : S_EST;
                S_RD_HI: begin
                    lo_key_reg <= key_rd_reg;
                    state_reg  <= S_EST;
                end
                S_EST: begin
                    lo_key_reg <= lo_cur;
                    hi_key_reg <= key_rd_reg;
                    if (hi_valid_reg) begin
                        ofs_reg <= first_diff;
                    end
                    state_reg <= S_VAL;
                end
                S_VAL: begin
                    num_reg  <= product;
                    den_reg  <= hiv - lov;
                    rem_reg  <= '0;
                    dcnt_reg <= hil_pkg::DCNT_W'(hil_pkg::NUM_W - 1);
                    if (hi_valid_reg && ofs_reg >= 5'(hil_pkg::KEY_BYTES)) begin
                        err_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end else if (lov >= hiv) begin
                        err_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end else if (kyv < lov || hiv < kyv) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg  <= rem_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                    num_reg  <= {num_reg[hil_pkg::NUM_W-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg - hil_pkg::DCNT_W'(1);
                    if (dcnt_reg == '0) begin
                        state_reg <= S_MID;
                    end
                end
                S_MID: begin
                    mi_reg <= mi_sum[hil_pkg::IDX_W-1:0];
                    if (mi_sum >= (hil_pkg::NUM_W+1)'(hi_reg)) begin
                        err_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_PRB_RD;
                    end
                end
                S_PRB_RD: state_reg <= S_PRB_CMP;
                S_PRB_CMP: begin
                    if (probe_m == key_m) begin
                        found_reg <= 1'b1;
                        pos_reg   <= mi_reg;
                        state_reg <= S_OFS_RD;
                    end else if (probe_m > key_m) begin
                        hi_reg       <= mi_ext;
                        hi_valid_reg <= 1'b1;
                        state_reg    <= (lo_reg < mi_ext) ? S_RD_LO : S_DONE;
                    end else begin
                        lo_reg    <= lo_up;
                        state_reg <= (lo_up < hi_reg) ? S_RD_LO : S_DONE;
                    end
                end
                S_OFS_RD: state_reg <= S_OFS_USE;
                S_OFS_USE: begin
                    if (!ofs_rd_reg[31]) begin
                        offset_reg <= {32'd0, ofs_rd_reg};
                        state_reg  <= S_DONE;
                    end else if (ofs_rd_reg[30:hil_pkg::IDX_W] == '0) begin
                        state_reg <= S_LRG_USE;
                    end else begin
                        err_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_LRG_USE: begin
                    offset_reg <= large_rd_reg;
                    state_reg  <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Output beat payload.
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {4'd0, err_reg, offset_reg, pos_reg, found_reg};
        end
    end

    `include "hash_index_lookup_top_assert.svh"

    `HIL_ASSERT_SAME(a_probe_in_range, state_reg == S_PRB_RD, mi_ext >= lo_reg && mi_ext < hi_reg, "probe index outside search range")
    `HIL_ASSERT_SAME(a_div_nonzero, state_reg == S_DIV, den_reg != '0, "divider started with zero divisor")
    `HIL_ASSERT_NEXT(a_accept_busy, in_accept, state_reg != S_IDLE, "accepted beat did not start work")

endmodule
